@@ rtl/qr_data_zigzag_placer_defines.svh @@
// Assertion macros for the QR data zigzag placer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef QR_DATA_ZIGZAG_PLACER_DEFINES_SVH
`define QR_DATA_ZIGZAG_PLACER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QRZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QRZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qrz_pkg.sv @@
// Shared types, constants and version tables for the QR data zigzag placer.
// No dependencies; used by every module of the block.
`default_nettype none

package qrz_pkg;

  localparam int unsigned CENTER_IDX_W = 3;
  localparam int unsigned TABLE_COLS   = 7;

  localparam logic [5:0] VERSION_MIN   = 6'd1;
  localparam logic [5:0] VERSION_MAX   = 6'd40;
  localparam logic [5:0] VERSION_RESET = 6'd1;
  localparam logic [7:0] SIDE_BASE     = 8'd21;

  localparam logic [7:0] TIMING_LINE    = 8'd6;
  localparam logic [7:0] ALIGN_SPAN     = 8'd5;
  localparam logic [7:0] FINDER_SPAN    = 8'd8;
  localparam logic [7:0] VERSION_SPAN   = 8'd11;
  localparam logic [7:0] ALIGN_NEAR_LIM = 8'd10;
  localparam logic [5:0] VERSION_AREA_MIN = 6'd7;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       done;
  } cursor_t;

  typedef struct packed {
    logic       restart;
    logic       advance;
    logic [7:0] restart_side;
    logic [7:0] side;
  } cursor_cmd_t;

  typedef logic [0:5][7:0] centers_t;

  function automatic logic [5:0] eff_version(input logic [5:0] v);
    logic [5:0] e;
    e = v;
    if (v < VERSION_MIN) e = VERSION_MIN;
    if (v > VERSION_MAX) e = VERSION_MAX;
    return e;
  endfunction

  function automatic logic [7:0] side_of(input logic [5:0] v);
    logic [7:0] e;
    e = {2'b00, eff_version(v)};
    return ((e - 8'd1) << 2) + SIDE_BASE;
  endfunction

  function automatic logic [2:0] align_count(input logic [5:0] v);
    logic [2:0] n;
    case (v) inside
      [6'd2:6'd6]:   n = 3'd2;
      [6'd7:6'd13]:  n = 3'd3;
      [6'd14:6'd20]: n = 3'd4;
      [6'd21:6'd27]: n = 3'd5;
      [6'd28:6'd40]: n = 3'd6;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic centers_t align_row(input logic [5:0] v);
    centers_t c;
    case (v)
      6'd2:  c = {8'd6, 8'd18, 32'd0};
      6'd3:  c = {8'd6, 8'd22, 32'd0};
      6'd4:  c = {8'd6, 8'd26, 32'd0};
      6'd5:  c = {8'd6, 8'd30, 32'd0};
      6'd6:  c = {8'd6, 8'd34, 32'd0};
      6'd7:  c = {8'd6, 8'd22, 8'd38, 24'd0};
      6'd8:  c = {8'd6, 8'd24, 8'd42, 24'd0};
      6'd9:  c = {8'd6, 8'd26, 8'd46, 24'd0};
      6'd10: c = {8'd6, 8'd28, 8'd50, 24'd0};
      6'd11: c = {8'd6, 8'd30, 8'd54, 24'd0};
      6'd12: c = {8'd6, 8'd32, 8'd58, 24'd0};
      6'd13: c = {8'd6, 8'd34, 8'd62, 24'd0};
      6'd14: c = {8'd6, 8'd26, 8'd46, 8'd66, 16'd0};
      6'd15: c = {8'd6, 8'd26, 8'd48, 8'd70, 16'd0};
      6'd16: c = {8'd6, 8'd26, 8'd50, 8'd74, 16'd0};
      6'd17: c = {8'd6, 8'd30, 8'd54, 8'd78, 16'd0};
      6'd18: c = {8'd6, 8'd30, 8'd56, 8'd82, 16'd0};
      6'd19: c = {8'd6, 8'd30, 8'd58, 8'd86, 16'd0};
      6'd20: c = {8'd6, 8'd34, 8'd62, 8'd90, 16'd0};
      6'd21: c = {8'd6, 8'd28, 8'd50, 8'd72, 8'd94, 8'd0};
      6'd22: c = {8'd6, 8'd26, 8'd50, 8'd74, 8'd98, 8'd0};
      6'd23: c = {8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd0};
      6'd24: c = {8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd0};
      6'd25: c = {8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd0};
      6'd26: c = {8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd0};
      6'd27: c = {8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd0};
      6'd28: c = {8'd6, 8'd26, 8'd50, 8'd74, 8'd98, 8'd122};
      6'd29: c = {8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126};
      6'd30: c = {8'd6, 8'd26, 8'd52, 8'd78, 8'd104, 8'd130};
      6'd31: c = {8'd6, 8'd30, 8'd56, 8'd82, 8'd108, 8'd134};
      6'd32: c = {8'd6, 8'd34, 8'd60, 8'd86, 8'd112, 8'd138};
      6'd33: c = {8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142};
      6'd34: c = {8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd146};
      6'd35: c = {8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126};
      6'd36: c = {8'd6, 8'd24, 8'd50, 8'd76, 8'd102, 8'd128};
      6'd37: c = {8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd132};
      6'd38: c = {8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd136};
      6'd39: c = {8'd6, 8'd26, 8'd54, 8'd82, 8'd110, 8'd138};
      6'd40: c = {8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] align_center(input logic [5:0] v,
                                              input logic [CENTER_IDX_W-1:0] idx);
    centers_t c;
    logic [7:0] p;
    c = align_row(v);
    p = 8'd0;
    if (idx < CENTER_IDX_W'(TABLE_COLS - 1)) p = c[idx];
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/qr_data_zigzag_placer.sv @@
// Top level of the QR data zigzag placer: handshakes, scan sequencer, result register.
// Depends on qrz_pkg, qrz_cursor, qrz_cell_check and the assertion macro header.
//
//   channel  dir  handshake                    payload
//   in       in   in_valid_i / in_stall_o      data_bit_i, start_symbol_i
//   out      out  out_valid_o / out_stall_i    module_row_o, module_col_o,
//                                              module_value_o, matrix_full_o
//   cfg      in   cfg_valid_i / cfg_ready_o    symbol_version_i
//
// A beat is accepted in the idle state; the scan state then visits the cells up to and including
// the data module used (one cell when the next cell is free, more across function areas).
// Unless held, the cursor steps one cell per cycle through the single shared classifier.
// Reset sets version 1 and parks the cursor at the bottom-right corner.
// A beat may enter while the last result waits; a scan that finds its module or the
// end of the walk holds until the result register frees.
`default_nettype none
`include "qr_data_zigzag_placer_defines.svh"

module qr_data_zigzag_placer #(
  parameter int unsigned MAX_CENTERS = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       data_bit_i,
  input  wire logic       start_symbol_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      module_row_o,
  output logic [7:0]      module_col_o,
  output logic            module_value_o,
  output logic            matrix_full_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [5:0] symbol_version_i
);

  qrz_pkg::state_e      state_q, state_d;
  qrz_pkg::cursor_cmd_t cmd;
  qrz_pkg::cursor_t     cur;

  logic [5:0] version_q, eff_ver;
  logic [7:0] side;
  logic       bit_q;
  logic       in_acc, cfg_wr, out_free, is_data;
  logic       load, load_full;
  logic       out_valid_q, out_valid_d;
  logic [7:0] row_q, col_q;
  logic       value_q, full_q;
  logic       pay_zero, off_timing, at_corner;

  assign eff_ver  = qrz_pkg::eff_version(version_q);
  assign side     = qrz_pkg::side_of(version_q);
  assign in_stall_o  = state_q != qrz_pkg::ST_IDLE;
  assign cfg_ready_o = state_q == qrz_pkg::ST_IDLE;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || !out_stall_i;

  qrz_cell_check #(
    .MAX_CENTERS (MAX_CENTERS)
  ) u_check (
    .version_i (eff_ver),
    .side_i    (side),
    .row_i     (cur.row),
    .col_i     (cur.col),
    .is_data_o (is_data)
  );

  qrz_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cur_o  (cur)
  );

  always_comb begin
    state_d          = state_q;
    load             = 1'b0;
    load_full        = 1'b0;
    cmd.restart      = cfg_wr || (in_acc && start_symbol_i);
    cmd.advance      = 1'b0;
    cmd.restart_side = cfg_wr ? qrz_pkg::side_of(symbol_version_i) : side;
    cmd.side         = side;
    case (state_q)
      qrz_pkg::ST_IDLE: begin
        if (in_acc) state_d = qrz_pkg::ST_SCAN;
      end
      qrz_pkg::ST_SCAN: begin
        if (cur.done) begin
          if (out_free) begin
            load      = 1'b1;
            load_full = 1'b1;
            state_d   = qrz_pkg::ST_IDLE;
          end
        end else if (is_data) begin
          if (out_free) begin
            load        = 1'b1;
            cmd.advance = 1'b1;
            state_d     = qrz_pkg::ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: state_d = qrz_pkg::ST_IDLE;
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qrz_pkg::ST_IDLE;
      version_q   <= qrz_pkg::VERSION_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) version_q <= symbol_version_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) bit_q <= data_bit_i;
    if (load) begin
      row_q   <= load_full ? 8'd0 : cur.row;
      col_q   <= load_full ? 8'd0 : cur.col;
      value_q <= load_full ? 1'b0 : bit_q;
      full_q  <= load_full;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign module_row_o   = row_q;
  assign module_col_o   = col_q;
  assign module_value_o = value_q;
  assign matrix_full_o  = full_q;

  assign pay_zero   = module_row_o == 8'd0 && module_col_o == 8'd0 && !module_value_o;
  assign off_timing = module_row_o != qrz_pkg::TIMING_LINE &&
                      module_col_o != qrz_pkg::TIMING_LINE;
  assign at_corner  = !cur.done && cur.row == side - 8'd1 && cur.col == side - 8'd1;

  `QRZ_ASSERT_IMP(a_full_zero, out_valid_o && matrix_full_o, pay_zero, "full beat payload")
  `QRZ_ASSERT_IMP(a_off_timing, out_valid_o && !matrix_full_o, off_timing, "timing hit")
  `QRZ_ASSERT_NXT(a_restart, in_acc && start_symbol_i, at_corner, "start missed corner")

endmodule

`default_nettype wire

@@ rtl/qrz_cell_check.sv @@
// Data-module classifier: flags whether a cell is free for data.
// Depends on qrz_pkg for the version tables and fixed symbol geometry.
`default_nettype none

module qrz_cell_check #(
  parameter int unsigned MAX_CENTERS = 6
) (
  input  wire logic [5:0] version_i,
  input  wire logic [7:0] side_i,
  input  wire logic [7:0] row_i,
  input  wire logic [7:0] col_i,
  output logic            is_data_o
);

  logic [2:0] n_used;
  logic [MAX_CENTERS-1:0] row_in, col_in, near_lo, near_hi;
  logic finder, timing, ver_area, align_hit;
  logic [8:0] r9, c9, s9;

  always_comb begin
    n_used = qrz_pkg::align_count(version_i);
    if (n_used > 3'(MAX_CENTERS)) n_used = 3'(MAX_CENTERS);
    r9 = {1'b0, row_i} + 9'd2;
    c9 = {1'b0, col_i} + 9'd2;
    s9 = {1'b0, side_i};
  end

  for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_ctr
    logic [8:0] pos;
    logic       used;
    assign pos  = {1'b0, qrz_pkg::align_center(version_i, qrz_pkg::CENTER_IDX_W'(g))};
    assign used = qrz_pkg::CENTER_IDX_W'(g) < n_used;
    assign row_in[g]  = used && (r9 >= pos) && (r9 < pos + {1'b0, qrz_pkg::ALIGN_SPAN});
    assign col_in[g]  = used && (c9 >= pos) && (c9 < pos + {1'b0, qrz_pkg::ALIGN_SPAN});
    assign near_lo[g] = pos <= {1'b0, qrz_pkg::ALIGN_NEAR_LIM};
    assign near_hi[g] = pos + {1'b0, qrz_pkg::ALIGN_NEAR_LIM} >= s9;
  end

  always_comb begin
    finder = ((row_i <= qrz_pkg::FINDER_SPAN) && (col_i <= qrz_pkg::FINDER_SPAN)) ||
             ((row_i <= qrz_pkg::FINDER_SPAN) && (col_i >= side_i - qrz_pkg::FINDER_SPAN)) ||
             ((row_i >= side_i - qrz_pkg::FINDER_SPAN) && (col_i <= qrz_pkg::FINDER_SPAN));
    timing = (row_i == qrz_pkg::TIMING_LINE) || (col_i == qrz_pkg::TIMING_LINE);
    ver_area = 1'b0;
    if (version_i >= qrz_pkg::VERSION_AREA_MIN) begin
      if ((row_i >= side_i - qrz_pkg::VERSION_SPAN) &&
          (row_i < side_i - qrz_pkg::FINDER_SPAN) && (col_i < qrz_pkg::TIMING_LINE))
        ver_area = 1'b1;
      if ((row_i < qrz_pkg::TIMING_LINE) && (col_i >= side_i - qrz_pkg::VERSION_SPAN) &&
          (col_i < side_i - qrz_pkg::FINDER_SPAN))
        ver_area = 1'b1;
    end
    align_hit = 1'b0;
    for (int i = 0; i < MAX_CENTERS; i++) begin
      for (int j = 0; j < MAX_CENTERS; j++) begin
        if (row_in[i] && col_in[j] &&
            !((near_lo[i] && near_lo[j]) || (near_lo[i] && near_hi[j]) ||
              (near_hi[i] && near_lo[j])))
          align_hit = 1'b1;
      end
    end
    is_data_o = !finder && !timing && !ver_area && !align_hit;
  end

endmodule

`default_nettype wire

@@ rtl/qrz_cursor.sv @@
// Zigzag walk cursor: position, timing-column skip and end-of-walk flag.
// Depends on qrz_pkg for the command and cursor structs.
`default_nettype none

module qrz_cursor (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire qrz_pkg::cursor_cmd_t cmd_i,
  output qrz_pkg::cursor_t          cur_o
);

  logic [7:0] row_q, row_d, col_q, col_d;
  logic       ts_q, ts_d, done_q, done_d;
  logic [7:0] side, side_m1, col_m1;
  logic [1:0] phase;
  logic       left;

  always_comb begin
    side    = cmd_i.side;
    side_m1 = side - 8'd1;
    phase   = 2'(side_m1 - col_q - {7'd0, ts_q});
    row_d   = row_q;
    col_d   = col_q;
    ts_d    = ts_q;
    done_d  = done_q;
    left    = 1'b0;
    col_m1  = col_q - 8'd1;
    if (cmd_i.restart) begin
      row_d  = cmd_i.restart_side - 8'd1;
      col_d  = cmd_i.restart_side - 8'd1;
      ts_d   = 1'b0;
      done_d = 1'b0;
    end else if (cmd_i.advance) begin
      if (phase == 2'd1 && row_q != 8'd0) begin
        row_d = row_q - 8'd1;
        col_d = col_q + 8'd1;
      end else if (phase == 2'd3 && row_q != side_m1) begin
        row_d = row_q + 8'd1;
        col_d = col_q + 8'd1;
      end else begin
        left = 1'b1;
      end
      if (left && col_q == 8'd0) begin
        done_d = 1'b1;
      end else begin
        if (left) col_d = col_m1;
        if (col_d == qrz_pkg::TIMING_LINE) begin
          col_d = qrz_pkg::TIMING_LINE - 8'd1;
          ts_d  = 1'b1;
        end
        if (row_d >= side || col_d >= side || (row_d == side_m1 && col_d == 8'd0))
          done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= qrz_pkg::SIDE_BASE - 8'd1;
      col_q  <= qrz_pkg::SIDE_BASE - 8'd1;
      ts_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      ts_q   <= ts_d;
      done_q <= done_d;
    end
  end

  assign cur_o = '{row: row_q, col: col_q, done: done_q};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for qr_data_zigzag_placer: checks row, column, value and full flag of every beat.
// Uses an in-file zigzag placement predictor and constants from qrz_pkg.
// Needs qrz_pkg and the placer RTL; reads no files.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned FILL_ITEMS   = 212;
  localparam int unsigned IDLE_PAUSE   = 6;
  localparam int unsigned END_PAUSE    = 40;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic       value;
    logic       full;
  } placement_t;

  typedef struct packed {
    logic       wr_version;
    logic [5:0] version;
    logic       data;
    logic       start;
    logic       known;
    logic [7:0] row;
    logic [7:0] col;
  } directed_t;

  localparam int unsigned N_DIRECTED = 22;
  localparam directed_t DIRECTED [0:N_DIRECTED-1] = '{
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'd20,  8'd20},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b1, 8'd20,  8'd19},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'd19,  8'd20},
    '{1'b0, 6'd0,  1'b0, 1'b1, 1'b1, 8'd20,  8'd20},
    '{1'b0, 6'd0,  1'b1, 1'b1, 1'b1, 8'd20,  8'd20},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b1, 8'd20,  8'd19},
    '{1'b1, 6'd0,  1'b1, 1'b0, 1'b1, 8'd20,  8'd20},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{1'b1, 6'd63, 1'b1, 1'b0, 1'b1, 8'd176, 8'd176},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b1, 8'd176, 8'd175},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b1, 8'd175, 8'd176},
    '{1'b1, 6'd40, 1'b0, 1'b1, 1'b1, 8'd176, 8'd176},
    '{1'b0, 6'd0,  1'b1, 1'b0, 1'b0, 8'd0,   8'd0},
    '{1'b1, 6'd7,  1'b1, 1'b0, 1'b1, 8'd44,  8'd44},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{1'b1, 6'd2,  1'b0, 1'b0, 1'b1, 8'd24,  8'd24},
    '{1'b0, 6'd0,  1'b1, 1'b1, 1'b1, 8'd24,  8'd24},
    '{1'b1, 6'd14, 1'b1, 1'b0, 1'b1, 8'd72,  8'd72},
    '{1'b1, 6'd21, 1'b0, 1'b0, 1'b1, 8'd100, 8'd100},
    '{1'b1, 6'd28, 1'b1, 1'b0, 1'b1, 8'd128, 8'd128},
    '{1'b0, 6'd0,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},
    '{1'b1, 6'd1,  1'b1, 1'b0, 1'b1, 8'd20,  8'd20}
  };

  localparam logic [7:0] CENTER_TAB [0:40][0:5] = '{
    '{8'd0, 8'd0,  8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd0, 8'd0,  8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd18, 8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd22, 8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd26, 8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd30, 8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd34, 8'd0,  8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd22, 8'd38, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd24, 8'd42, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd26, 8'd46, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd28, 8'd50, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd30, 8'd54, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd32, 8'd58, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd34, 8'd62, 8'd0,  8'd0,   8'd0},
    '{8'd6, 8'd26, 8'd46, 8'd66, 8'd0,   8'd0},
    '{8'd6, 8'd26, 8'd48, 8'd70, 8'd0,   8'd0},
    '{8'd6, 8'd26, 8'd50, 8'd74, 8'd0,   8'd0},
    '{8'd6, 8'd30, 8'd54, 8'd78, 8'd0,   8'd0},
    '{8'd6, 8'd30, 8'd56, 8'd82, 8'd0,   8'd0},
    '{8'd6, 8'd30, 8'd58, 8'd86, 8'd0,   8'd0},
    '{8'd6, 8'd34, 8'd62, 8'd90, 8'd0,   8'd0},
    '{8'd6, 8'd28, 8'd50, 8'd72, 8'd94,  8'd0},
    '{8'd6, 8'd26, 8'd50, 8'd74, 8'd98,  8'd0},
    '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd0},
    '{8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd0},
    '{8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd0},
    '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd0},
    '{8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd0},
    '{8'd6, 8'd26, 8'd50, 8'd74, 8'd98,  8'd122},
    '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126},
    '{8'd6, 8'd26, 8'd52, 8'd78, 8'd104, 8'd130},
    '{8'd6, 8'd30, 8'd56, 8'd82, 8'd108, 8'd134},
    '{8'd6, 8'd34, 8'd60, 8'd86, 8'd112, 8'd138},
    '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142},
    '{8'd6, 8'd34, 8'd62, 8'd90, 8'd118, 8'd146},
    '{8'd6, 8'd30, 8'd54, 8'd78, 8'd102, 8'd126},
    '{8'd6, 8'd24, 8'd50, 8'd76, 8'd102, 8'd128},
    '{8'd6, 8'd28, 8'd54, 8'd80, 8'd106, 8'd132},
    '{8'd6, 8'd32, 8'd58, 8'd84, 8'd110, 8'd136},
    '{8'd6, 8'd26, 8'd54, 8'd82, 8'd110, 8'd138},
    '{8'd6, 8'd30, 8'd58, 8'd86, 8'd114, 8'd142}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       data_bit_i;
  logic       start_symbol_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] module_row_o;
  logic [7:0] module_col_o;
  logic       module_value_o;
  logic       matrix_full_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [5:0] symbol_version_i;

  qr_data_zigzag_placer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_bit_i       (data_bit_i),
    .start_symbol_i   (start_symbol_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .module_row_o     (module_row_o),
    .module_col_o     (module_col_o),
    .module_value_o   (module_value_o),
    .matrix_full_o    (matrix_full_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .symbol_version_i (symbol_version_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  placement_t  placements_q[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned stall_mode;
  int unsigned stall_left;

  // walk state of the placement predictor
  logic [5:0]  placer_version;
  int unsigned walk_row;
  int unsigned walk_col;
  logic        timing_hopped;
  logic        walk_end;

  function automatic int unsigned clamp_version(input logic [5:0] v);
    if (v == 6'd0) return 1;
    if (v > 6'd40) return 40;
    return v;
  endfunction

  function automatic int unsigned symbol_side(input int unsigned v);
    return (v - 1) * 4 + 21;
  endfunction

  function automatic int unsigned align_total(input int unsigned v);
    if (v < 2) return 0;
    if (v < 7) return 2;
    if (v < 14) return 3;
    if (v < 21) return 4;
    if (v < 28) return 5;
    return 6;
  endfunction

  function automatic bit in_corner_area(input int unsigned side, input int unsigned r,
                                        input int unsigned c);
    return (r <= 8 && c <= 8) || (r <= 8 && c >= side - 8) || (r >= side - 8 && c <= 8);
  endfunction

  function automatic bit free_cell(input int unsigned v, input int unsigned side,
                                   input int unsigned r, input int unsigned c);
    int unsigned n;
    int unsigned cr;
    int unsigned cc;
    bit          touches;
    n = align_total(v);
    if (in_corner_area(side, r, c)) return 1'b0;
    if (r == qrz_pkg::TIMING_LINE || c == qrz_pkg::TIMING_LINE) return 1'b0;
    if (v >= 7) begin
      if (r >= side - 11 && r < side - 8 && c < 6) return 1'b0;
      if (r < 6 && c >= side - 11 && c < side - 8) return 1'b0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      cr = CENTER_TAB[v][i] - 2;
      if (!(cr <= r && r < cr + qrz_pkg::ALIGN_SPAN)) continue;
      for (int unsigned j = 0; j < n; j++) begin
        cc = CENTER_TAB[v][j] - 2;
        if (!(cc <= c && c < cc + qrz_pkg::ALIGN_SPAN)) continue;
        touches = 1'b0;
        for (int unsigned a = 0; a < qrz_pkg::ALIGN_SPAN; a++)
          for (int unsigned b = 0; b < qrz_pkg::ALIGN_SPAN; b++)
            if (in_corner_area(side, cr + a, cc + b)) touches = 1'b1;
        if (!touches) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic restart_walk();
    int unsigned side;
    side = symbol_side(clamp_version(placer_version));
    walk_row = side - 1;
    walk_col = side - 1;
    timing_hopped = 1'b0;
    walk_end = 1'b0;
  endtask

  task automatic step_cursor(input int unsigned side);
    int unsigned phase;
    bit          turn;
    phase = (side - 1 - walk_col - timing_hopped) & 3;
    turn = 1'b0;
    if (phase == 1 && walk_row > 0) begin
      walk_row--;
      walk_col++;
    end else if (phase == 3 && walk_row < side - 1) begin
      walk_row++;
      walk_col++;
    end else begin
      turn = 1'b1;
    end
    if (turn) begin
      if (walk_col == 0) begin
        walk_end = 1'b1;
        return;
      end
      walk_col--;
    end
    if (walk_col == qrz_pkg::TIMING_LINE) begin
      walk_col--;
      timing_hopped = 1'b1;
    end
    if (walk_row >= side || walk_col >= side || (walk_row == side - 1 && walk_col == 0))
      walk_end = 1'b1;
  endtask

  task automatic place_bit(input logic d, input logic s, output placement_t res);
    int unsigned v;
    int unsigned side;
    bit          found;
    v = clamp_version(placer_version);
    side = symbol_side(v);
    found = 1'b0;
    res = '0;
    if (s) restart_walk();
    if (walk_row >= side || walk_col >= side) walk_end = 1'b1;
    for (int unsigned guard = 0; guard < side * side + 8 && !walk_end && !found; guard++) begin
      if (free_cell(v, side, walk_row, walk_col)) begin
        res.row = walk_row[7:0];
        res.col = walk_col[7:0];
        res.value = d;
        found = 1'b1;
      end
      step_cursor(side);
    end
    if (!found) begin
      walk_end = 1'b1;
      res.full = 1'b1;
    end
  endtask

  task automatic send_beat(input logic d, input logic s, input logic known,
                           input logic [7:0] er, input logic [7:0] ec);
    placement_t pred;
    placement_t typed;
    in_valid_i <= 1'b1;
    data_bit_i <= d;
    start_symbol_i <= s;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    place_bit(d, s, pred);
    typed = '{row: er, col: ec, value: d, full: 1'b0};
    placements_q.push_back(known ? typed : pred);
    @(posedge clk_i);
  endtask

  task automatic between_beats();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (placements_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [5:0] v);
    cfg_valid_i <= 1'b1;
    symbol_version_i <= v;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    placer_version = v;
    restart_walk();
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  always @(negedge clk_i) begin
    placement_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (placements_q.size() == 0) begin
        report("unexpected beat", 0, 1);
      end else begin
        want = placements_q.pop_front();
        if (module_row_o !== want.row) report("module_row", want.row, module_row_o);
        if (module_col_o !== want.col) report("module_col", want.col, module_col_o);
        if (module_value_o !== want.value) report("module_value", want.value, module_value_o);
        if (matrix_full_o !== want.full) report("matrix_full", want.full, matrix_full_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned n;
    int unsigned pick;
    int unsigned tail;
    logic [5:0]  ver;
    logic        s;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_bit_i = 1'b0;
    start_symbol_i = 1'b0;
    cfg_valid_i = 1'b0;
    symbol_version_i = 6'd1;
    fail_count = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    placer_version = 6'd1;
    restart_walk();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].wr_version) begin
        drain();
        write_version(DIRECTED[i].version);
      end
      send_beat(DIRECTED[i].data, DIRECTED[i].start, DIRECTED[i].known,
                DIRECTED[i].row, DIRECTED[i].col);
      between_beats();
    end

    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_no % 4 == 1) begin
        // fill a version-1 symbol, run past its end, then restart the walk
        ver = (phase_no % 8 == 1) ? 6'd1 : 6'd0;
        n = FILL_ITEMS + $urandom_range(0, 12);
        tail = $urandom_range(2, 8);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 12) ver = 6'($urandom_range(1, 6));
        else if (pick < 17) ver = 6'($urandom_range(7, 40));
        else if (pick == 17) ver = 6'd0;
        else if (pick == 18) ver = 6'd63;
        else ver = 6'($urandom_range(41, 62));
        n = $urandom_range(10, 70);
        tail = 0;
      end
      drain();
      write_version(ver);
      for (int unsigned k = 0; k < n + tail; k++) begin
        if (k == 0) s = 1'($urandom_range(0, 1));
        else if (k == n) s = 1'b1;
        else s = ($urandom_range(0, 31) == 0) && (tail == 0);
        send_beat(1'($urandom_range(0, 1)), s, 1'b0, 8'd0, 8'd0);
        between_beats();
      end
      sent += n + tail;
      phase_no++;
    end

    drain();
    repeat (END_PAUSE) @(posedge clk_i);
    if (fail_count == 0 && placements_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/qrz_pkg.sv
rtl/qrz_cell_check.sv
rtl/qrz_cursor.sv
rtl/qr_data_zigzag_placer.sv
tb/tb.sv
